// ===== rtl/core/c2p_pkg.sv =====
`default_nettype none
package c2p_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int PLANE_COUNT  = 4;
  localparam int GROUP_PIXELS = 16;
  localparam int COLOR_W      = 8;
  localparam int COLOR_MAX    = 15;
  localparam int WIDTH_W      = 13;
  localparam int COL_W        = 12;
  localparam int POS_W        = $clog2(GROUP_PIXELS);

  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [PLANE_COUNT-1:0][GROUP_PIXELS-1:0] planes_t;

  typedef struct packed {
    planes_t planes;
    logic    row_end;
    logic    image_end;
    logic    bad_pixel;
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t grp;
  } group_beat_t;

endpackage
`default_nettype wire

// ===== rtl/core/c2p_pix_if.sv =====
`default_nettype none
interface c2p_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_color;
  logic       image_last;

  modport source (output valid, output pixel_color, output image_last, input ready);
  modport sink   (input valid, input pixel_color, input image_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/c2p_grp_if.sv =====
`default_nettype none
interface c2p_grp_if;
  logic        valid;
  logic        ready;
  logic [15:0] plane0_word;
  logic [15:0] plane1_word;
  logic [15:0] plane2_word;
  logic [15:0] plane3_word;
  logic        row_end;
  logic        image_end;
  logic        bad_pixel;

  modport source (output valid, output plane0_word, output plane1_word, output plane2_word,
                  output plane3_word, output row_end, output image_end, output bad_pixel,
                  input ready);
  modport sink   (input valid, input plane0_word, input plane1_word, input plane2_word,
                  input plane3_word, input row_end, input image_end, input bad_pixel,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/c2p_cfg_if.sv =====
`default_nettype none
interface c2p_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] image_width;

  modport source (output valid, output image_width, input ready);
  modport sink   (input valid, input image_width, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/chunky_to_planar_packer.sv =====
// Chunky-to-planar packer, four interleaved bit planes.
// in_bus  : one indexed pixel per beat, row order, image_last on the last pixel.
// out_bus : one beat per group of 16 pixels (or fewer at row or image end),
//           four plane words with the leftmost pixel at bit 15, zero padded,
//           plus row_end, image_end and bad_pixel (a pixel above 15 in the group).
// cfg_bus : image_width write, always ready; write it only while idle.
//           0 acts as 1, values above 4096 act as 4096.
// Throughput: one pixel per cycle while in_bus.ready is high; the pack step is a single pass of
// bit-insert logic into the plane accumulators.
// The group beat is registered in the output buffer before it appears on out_bus;
// a stalled receiver can hold it in the second entry.
// A two-entry output buffer holds results while the receiver stalls; pixels
// keep flowing until both entries are full, then in_bus.ready drops.
// Reset (rst_n low, synchronous): width returns to 1, column, accumulators
// and error flag clear, output buffer empties.
`default_nettype none
module chunky_to_planar_packer
  import c2p_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  c2p_pix_if.sink   in_bus,
  c2p_grp_if.source out_bus,
  c2p_cfg_if.sink   cfg_bus
);

  width_t      image_width_r;
  logic        in_ready;
  logic        accept;
  group_beat_t res;
  group_t      out_grp;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= WIDTH_W'(1);
    end else if (cfg_bus.valid) begin
      image_width_r <= cfg_bus.image_width;
    end
  end

  assign in_bus.ready = in_ready;
  assign accept       = in_bus.valid && in_ready;

  c2p_pack u_pack (
    .clk         (clk),
    .rst_n       (rst_n),
    .image_width (image_width_r),
    .accept      (accept),
    .pixel_color (in_bus.pixel_color),
    .image_last  (in_bus.image_last),
    .res         (res)
  );

  c2p_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res),
    .push_ready (in_ready),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_grp    (out_grp)
  );

  assign out_bus.plane0_word = out_grp.planes[0];
  assign out_bus.plane1_word = out_grp.planes[1];
  assign out_bus.plane2_word = out_grp.planes[2];
  assign out_bus.plane3_word = out_grp.planes[3];
  assign out_bus.row_end     = out_grp.row_end;
  assign out_bus.image_end   = out_grp.image_end;
  assign out_bus.bad_pixel   = out_grp.bad_pixel;

  a_stall_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_bus.valid)
    else $error("input stalled with no pending result");

  a_result_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> accept)
    else $error("result without accepted pixel");

  a_last_closes_group: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_bus.image_last) |-> res.valid)
    else $error("image end did not close a group");

  a_image_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.grp.image_end) |-> res.grp.row_end)
    else $error("image end without row end");

endmodule
`default_nettype wire

// ===== rtl/core/c2p_pack.sv =====
`default_nettype none
module c2p_pack
  import c2p_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire width_t             image_width,
  input  wire logic               accept,
  input  wire logic [COLOR_W-1:0] pixel_color,
  input  wire logic               image_last,
  output group_beat_t             res
);

  localparam width_t MAX_W = WIDTH_W'(MAX_WIDTH);
  localparam pos_t   LAST_POS = POS_W'(GROUP_PIXELS - 1);

  col_t    col_r, col_nxt;
  planes_t acc_r, acc_nxt;
  logic    err_r, err_nxt;

  width_t eff_width;
  pos_t   pos;
  pos_t   shift;
  logic   row_done;
  logic   group_done;
  logic [WIDTH_W-1:0] col_inc;

  always_comb begin
    if (image_width == '0) begin
      eff_width = WIDTH_W'(1);
    end else if (image_width > MAX_W) begin
      eff_width = MAX_W;
    end else begin
      eff_width = image_width;
    end
  end

  assign pos     = col_r[POS_W-1:0];
  assign shift   = LAST_POS - pos;
  assign col_inc = {1'b0, col_r} + WIDTH_W'(1);

  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      acc_nxt[p] = acc_r[p] | (GROUP_PIXELS'(pixel_color[p]) << shift);
    end
  end

  assign err_nxt    = err_r || (pixel_color > COLOR_W'(COLOR_MAX));
  assign row_done   = (col_inc >= eff_width) || image_last;
  assign group_done = row_done || (pos == LAST_POS);
  assign col_nxt    = row_done ? '0 : col_inc[COL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      acc_r <= '0;
      err_r <= 1'b0;
    end else if (accept) begin
      col_r <= col_nxt;
      if (group_done) begin
        acc_r <= '0;
        err_r <= 1'b0;
      end else begin
        acc_r <= acc_nxt;
        err_r <= err_nxt;
      end
    end
  end

  assign res.valid         = accept && group_done;
  assign res.grp.planes    = acc_nxt;
  assign res.grp.row_end   = row_done;
  assign res.grp.image_end = image_last;
  assign res.grp.bad_pixel = err_nxt;

endmodule
`default_nettype wire

// ===== rtl/core/c2p_out_buf.sv =====
`default_nettype none
module c2p_out_buf
  import c2p_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire group_beat_t push,
  output logic             push_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output group_t           out_grp
);

  logic   out_v_r, skid_v_r;
  group_t out_r, skid_r;
  logic   pop;

  assign pop        = out_v_r && out_ready;
  assign push_ready = !skid_v_r;
  assign out_valid  = out_v_r;
  assign out_grp    = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push.valid && out_v_r && !pop) begin
      skid_v_r <= 1'b1;
    end else if (push.valid) begin
      out_v_r <= 1'b1;
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push.valid && out_v_r && !pop) begin
      skid_r <= push.grp;
    end else if (push.valid) begin
      out_r <= push.grp;
    end
  end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import c2p_pkg::*;

  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_EDGES   = 4;
  localparam int MAX_ROW_PIXELS = 300;
  localparam int RANDOM_GOAL    = 1300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  c2p_pix_if pix_bus ();
  c2p_grp_if grp_bus ();
  c2p_cfg_if cfg_bus ();

  chunky_to_planar_packer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (pix_bus),
    .out_bus (grp_bus),
    .cfg_bus (cfg_bus)
  );

  always #5 clk = ~clk;

  // packer state as predicted
  width_t            width_reg;
  col_t              column;
  logic [15:0]       plane_acc [PLANE_COUNT];
  logic              group_bad;
  group_t            pending_groups [$];

  int mismatches = 0;
  int pixels_sent = 0;
  int groups_seen = 0;
  int width_writes = 0;
  int burst_left = 0;

  task automatic report(string msg);
    if (mismatches < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int eff_width(int w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH) return MAX_WIDTH;
    return w;
  endfunction

  task automatic pack_pixel(logic [7:0] color, logic last);
    int pos;
    bit row_done;
    group_t g;
    pos = int'(column) % GROUP_PIXELS;
    for (int p = 0; p < PLANE_COUNT; p++)
      if (color[p]) plane_acc[p][GROUP_PIXELS-1-pos] = 1'b1;
    if (color > COLOR_MAX) group_bad = 1'b1;
    row_done = (int'(column) + 1 >= eff_width(int'(width_reg))) || last;
    column = row_done ? '0 : col_t'(column + 1'b1);
    if (row_done || pos == GROUP_PIXELS - 1) begin
      for (int p = 0; p < PLANE_COUNT; p++) g.planes[p] = plane_acc[p];
      g.row_end = row_done;
      g.image_end = last;
      g.bad_pixel = group_bad;
      pending_groups.push_back(g);
      for (int p = 0; p < PLANE_COUNT; p++) plane_acc[p] = '0;
      group_bad = 1'b0;
    end
  endtask

  task automatic check_group();
    group_t want;
    logic [15:0] got [PLANE_COUNT];
    if (pending_groups.size() == 0) begin
      report("group beat with nothing expected");
      return;
    end
    want = pending_groups.pop_front();
    got[0] = grp_bus.plane0_word;
    got[1] = grp_bus.plane1_word;
    got[2] = grp_bus.plane2_word;
    got[3] = grp_bus.plane3_word;
    for (int p = 0; p < PLANE_COUNT; p++)
      if (got[p] !== want.planes[p])
        report($sformatf("group %0d plane%0d got %h want %h", groups_seen, p, got[p],
                         want.planes[p]));
    if (grp_bus.row_end !== want.row_end)
      report($sformatf("group %0d row_end got %b want %b", groups_seen, grp_bus.row_end,
                       want.row_end));
    if (grp_bus.image_end !== want.image_end)
      report($sformatf("group %0d image_end got %b want %b", groups_seen, grp_bus.image_end,
                       want.image_end));
    if (grp_bus.bad_pixel !== want.bad_pixel)
      report($sformatf("group %0d bad_pixel got %b want %b", groups_seen, grp_bus.bad_pixel,
                       want.bad_pixel));
    groups_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = width_t'(1);
      column = '0;
      for (int p = 0; p < PLANE_COUNT; p++) plane_acc[p] = '0;
      group_bad = 1'b0;
      pending_groups.delete();
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) width_reg = cfg_bus.image_width;
      if (pix_bus.valid && pix_bus.ready) pack_pixel(pix_bus.pixel_color, pix_bus.image_last);
      if (grp_bus.valid && grp_bus.ready) check_group();
    end
  end

  // receiver stall pattern, re-chosen at random among always ready, random and periodic
  initial begin
    int mode;
    int cyc;
    int period;
    int low_len;
    mode = 0;
    cyc = 0;
    period = 4;
    low_len = 1;
    grp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cyc % 100 == 0) begin
        mode = $urandom_range(0, 2);
        period = $urandom_range(3, 12);
        low_len = $urandom_range(1, period - 1);
      end
      case (mode)
        0: grp_bus.ready <= 1'b1;
        1: grp_bus.ready <= ($urandom_range(0, 3) != 0);
        default: grp_bus.ready <= ((cyc % period) >= low_len);
      endcase
      cyc++;
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((pix_bus.valid && pix_bus.ready) || (grp_bus.valid && grp_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        idle = 0;
      else
        idle++;
      if (idle >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic push_pixel(logic [7:0] color, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.pixel_color <= color;
    pix_bus.image_last <= last;
    do @(posedge clk); while (!pix_bus.ready);
    burst_left--;
    pixels_sent++;
  endtask

  task automatic settle();
    pix_bus.valid <= 1'b0;
    burst_left = 0;
    do repeat (SETTLE_EDGES) @(posedge clk); while (pending_groups.size() != 0);
  endtask

  task automatic write_width(int w);
    settle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.image_width <= width_t'(w);
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
    width_writes++;
  endtask

  // width 1 after reset: every pixel is a one-pixel row
  task automatic test_reset_width();
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h0F, 1'b0);
    push_pixel(8'hFF, 1'b1);
    push_pixel(8'h10, 1'b0);
  endtask

  task automatic test_zero_width();
    write_width(0);
    push_pixel(8'hAA, 1'b0);
    push_pixel(8'h55, 1'b1);
  endtask

  // full group, bad pixel in a partial group, early image end, new row after it
  task automatic test_early_image_end();
    write_width(20);
    for (int i = 0; i < GROUP_PIXELS; i++) push_pixel(8'(i), 1'b0);
    push_pixel(8'h80, 1'b0);
    push_pixel(8'h0F, 1'b1);
    push_pixel(8'h03, 1'b0);
  endtask

  // oversized width: a long row stays open across many groups, closed by image_last
  task automatic test_max_row();
    logic [7:0] c;
    write_width(8191);
    for (int i = 0; i < MAX_ROW_PIXELS; i++) begin
      c = ($urandom_range(0, 31) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 15));
      push_pixel(c, i == MAX_ROW_PIXELS - 1);
    end
  endtask

  task automatic test_random_rasters();
    int sent;
    int w_set;
    int eff;
    int gen_col;
    int rows_left;
    int n;
    logic [7:0] c;
    logic l;
    sent = 0;
    while (sent < RANDOM_GOAL) begin
      case ($urandom_range(0, 11))
        0: w_set = 0;
        1: w_set = $urandom_range(100, 400);
        2: w_set = ($urandom_range(0, 1) != 0) ? MAX_WIDTH : $urandom_range(4097, 8191);
        3: w_set = $urandom_range(1, 3);
        default: w_set = $urandom_range(1, 40);
      endcase
      write_width(w_set);
      eff = eff_width(w_set);
      gen_col = int'(column);
      rows_left = $urandom_range(1, 4);
      n = $urandom_range(10, 120);
      repeat (n) begin
        c = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 15));
        l = 1'b0;
        if (gen_col + 1 >= eff) begin
          rows_left--;
          if (rows_left == 0) begin
            l = 1'b1;
            rows_left = $urandom_range(1, 4);
          end
        end else if ($urandom_range(0, 199) == 0) begin
          l = 1'b1;
        end
        push_pixel(c, l);
        gen_col = (gen_col + 1 >= eff || l) ? 0 : gen_col + 1;
        sent++;
      end
    end
  endtask

  initial begin
    pix_bus.valid <= 1'b0;
    pix_bus.pixel_color <= '0;
    pix_bus.image_last <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.image_width <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_width();
    test_zero_width();
    test_early_image_end();
    test_max_row();
    test_random_rasters();
    settle();

    $display("covered %0d pixels over %0d width settings, %0d group beats checked",
             pixels_sent, width_writes, groups_seen);
    $display("widths included zero, one, oversized values and random short rows");
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
